// File: hw/rtl/serpent_pkg.sv
// Serpent cipher package: payload and state types, S-box tables,
// bitsliced S-box and linear transform functions.
// Used by serpent_block_cipher_core; no dependencies.
`default_nettype none

package serpent_pkg;

   localparam logic [31:0] GOLDEN    = 32'h9e3779b9;
   localparam int          NUM_GRPS  = 33;
   localparam int          NUM_RNDS  = 32;
   localparam logic [7:0]  LAST_WORD = 8'd131;

   // key register indexes
   localparam logic [2:0] REG_KEY_LEN = 3'd0;
   localparam logic [2:0] REG_KEY_LAST = 3'd4;

   // key length codes
   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;

   typedef logic [3:0][31:0] block_type;

   typedef struct packed {
      logic        op;
      logic [63:0] block_low;
      logic [63:0] block_high;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
   } rsp_payload_type;

   typedef struct packed {
      logic      op;
      block_type data;
   } pipe_type;

   typedef enum logic [1:0] {
      EXP_IDLE,
      EXP_LOAD,
      EXP_RUN
   } exp_state_type;

   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
        4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
      '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
        4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
      '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
        4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
      '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
        4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
      '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
        4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
      '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
        4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
      '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
        4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
      '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
        4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
   };

   function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] rotr(logic [31:0] v, int unsigned n);
      return rotl(v, 32 - n);
   endfunction

   // inverse nibble lookup by search; box is constant at every use
   function automatic logic [3:0] inv_nib(logic [2:0] box, logic [3:0] n);
      logic [3:0] v;
      v = 4'd0;
      for (int k = 0; k < 16; k++) begin
         if (SBOX[box][k] == n) v = 4'(k);
      end
      return v;
   endfunction

   // bitsliced S-box: word j holds bit j of each nibble
   function automatic block_type sbox_apply(logic [2:0] box, logic inv, block_type x);
      block_type  y;
      logic [3:0] n;
      logic [3:0] v;
      y = '0;
      for (int b = 0; b < 32; b++) begin
         n = {x[3][b], x[2][b], x[1][b], x[0][b]};
         v = inv ? inv_nib(box, n) : SBOX[box][n];
         for (int j = 0; j < 4; j++) y[j][b] = v[j];
      end
      return y;
   endfunction

   function automatic block_type lin_fwd(block_type x);
      logic [31:0] a, b, c, d;
      block_type   y;
      a = rotl(x[0], 13);
      c = rotl(x[2], 3);
      b = x[1] ^ a ^ c;
      d = x[3] ^ c ^ (a << 3);
      b = rotl(b, 1);
      d = rotl(d, 7);
      a = a ^ b ^ d;
      c = c ^ d ^ (b << 7);
      y[0] = rotl(a, 5);
      y[1] = b;
      y[2] = rotl(c, 22);
      y[3] = d;
      return y;
   endfunction

   function automatic block_type lin_inv(block_type x);
      logic [31:0] a, b, c, d;
      block_type   y;
      c = rotr(x[2], 22);
      a = rotr(x[0], 5);
      c = c ^ x[3] ^ (x[1] << 7);
      a = a ^ x[1] ^ x[3];
      d = rotr(x[3], 7);
      b = rotr(x[1], 1);
      d = d ^ c ^ (a << 3);
      b = b ^ a ^ c;
      y[0] = rotr(a, 13);
      y[1] = b;
      y[2] = rotr(c, 3);
      y[3] = d;
      return y;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/serpent_block_cipher_core.sv
// Serpent block cipher core: key registers, key schedule sequencer,
// 32-stage round pipeline. Depends on serpent_pkg.
//
// Usage:
//  - csr_ channel writes the key length (index 0) and the four 64-bit key
//    words (indexes 1..4). Each write to a known index starts a key
//    schedule run (a load state, then one round-key word per cycle in
//    the run state); csr_ready is low and req_stall is high during it.
//    Writes to unknown indexes are dropped.
//  - req_ channel takes one block per beat, op 0 encrypts and 1 decrypts.
//  - rsp_ channel returns the result once it has passed the pipeline:
//    one input register plus one register per round.
//  - The round pipeline takes one block per cycle while req_stall is low.
//  - When the receiver stalls a valid result, the whole pipeline holds
//    and req_stall goes high; nothing is dropped or repeated.
//  - Reset clears valid bits, the sequencer and the key registers
//    (length 256 bits, key all zero). Round keys are undefined until the
//    first key write.
`default_nettype none

module serpent_block_cipher_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire serpent_pkg::req_payload_type  req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output serpent_pkg::rsp_payload_type       rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [63:0]                   csr_wdata
);

   // key registers
   logic [1:0]  key_len_ff;
   logic [63:0] key_ff [4];
   logic        csr_hit;

   // key schedule sequencer
   serpent_pkg::exp_state_type state_ff, state_in;
   logic [7:0]  cnt_ff;
   logic [31:0] win_ff [8];
   logic [31:0] grp_ff [3];
   logic [31:0] new_word;
   logic        exp_busy;
   serpent_pkg::block_type rk_ff [serpent_pkg::NUM_GRPS];

   // round pipeline
   serpent_pkg::pipe_type pipe_ff [serpent_pkg::NUM_RNDS + 1];
   serpent_pkg::pipe_type pipe_in [serpent_pkg::NUM_RNDS + 1];
   logic [serpent_pkg::NUM_RNDS:0] valid_ff;
   logic pipe_adv;
   logic req_beat;

   // csr write decode
   assign csr_hit = csr_valid && csr_ready && (csr_index <= serpent_pkg::REG_KEY_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= 2'd2;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_hit) begin
         if (csr_index == serpent_pkg::REG_KEY_LEN) begin
            key_len_ff <= csr_wdata[1:0];
         end else begin
            key_ff[2'(csr_index - 3'd1)] <= csr_wdata;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         serpent_pkg::EXP_IDLE: if (csr_hit) state_in = serpent_pkg::EXP_LOAD;
         serpent_pkg::EXP_LOAD: state_in = serpent_pkg::EXP_RUN;
         serpent_pkg::EXP_RUN: begin
            if (cnt_ff == serpent_pkg::LAST_WORD) state_in = serpent_pkg::EXP_IDLE;
         end
         default: state_in = serpent_pkg::EXP_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      case (state_ff)
         serpent_pkg::EXP_IDLE: begin
            csr_ready = 1'b1;
            exp_busy  = 1'b0;
         end
         default: begin
            csr_ready = 1'b0;
            exp_busy  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= serpent_pkg::EXP_IDLE;
      else       state_ff <= state_in;
   end

   // prekey recurrence over a sliding window of eight words
   assign new_word = serpent_pkg::rotl(win_ff[0] ^ win_ff[3] ^ win_ff[5] ^ win_ff[7]
                                       ^ serpent_pkg::GOLDEN ^ {24'd0, cnt_ff}, 11);

   always_ff @(posedge clock) begin
      if (state_ff == serpent_pkg::EXP_LOAD) begin
         cnt_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            win_ff[2*i]   <= key_ff[i][31:0];
            win_ff[2*i+1] <= key_ff[i][63:32];
         end
         // pad short keys with a one bit then zeros
         if (key_len_ff == serpent_pkg::KEY_LEN_128) begin
            win_ff[4] <= 32'd1;
            win_ff[5] <= '0;
            win_ff[6] <= '0;
            win_ff[7] <= '0;
         end else if (key_len_ff == serpent_pkg::KEY_LEN_192) begin
            win_ff[6] <= 32'd1;
            win_ff[7] <= '0;
         end
      end else if (state_ff == serpent_pkg::EXP_RUN) begin
         cnt_ff <= cnt_ff + 8'd1;
         for (int i = 0; i < 7; i++) win_ff[i] <= win_ff[i+1];
         win_ff[7] <= new_word;
         if (cnt_ff[1:0] != 2'd3) begin
            grp_ff[cnt_ff[1:0]] <= new_word;
         end else begin
            // full group of four: S-box (3 - group) mod 8
            rk_ff[6'(cnt_ff[7:2])] <= serpent_pkg::sbox_apply(
               3'(3'd3 - cnt_ff[4:2]), 1'b0, {new_word, grp_ff[2], grp_ff[1], grp_ff[0]});
         end
      end
   end

   // pipeline control: everything holds while a result waits
   assign pipe_adv  = !(rsp_valid && rsp_stall);
   assign req_stall = exp_busy || !pipe_adv;
   assign req_beat  = req_valid && !req_stall;

   // input stage
   always_comb begin
      pipe_in[0].op   = req_data.op;
      pipe_in[0].data = {req_data.block_high, req_data.block_low};
   end

   // one round per stage; both directions built, op picks one
   for (genvar k = 0; k < serpent_pkg::NUM_RNDS; k++) begin : g_round
      serpent_pkg::block_type enc_out, dec_out, t_enc, t_dec;

      always_comb begin
         t_enc = serpent_pkg::sbox_apply(3'(k & 7), 1'b0, pipe_ff[k].data ^ rk_ff[k]);
         if (k < serpent_pkg::NUM_RNDS - 1) enc_out = serpent_pkg::lin_fwd(t_enc);
         else                               enc_out = t_enc ^ rk_ff[serpent_pkg::NUM_RNDS];
      end

      if (k == 0) begin : g_first
         always_comb begin
            t_dec = serpent_pkg::sbox_apply(3'd7, 1'b1,
                                            pipe_ff[k].data ^ rk_ff[serpent_pkg::NUM_RNDS]);
            dec_out = t_dec ^ rk_ff[serpent_pkg::NUM_RNDS - 1];
         end
      end else begin : g_rest
         always_comb begin
            t_dec = serpent_pkg::sbox_apply(3'((31 - k) & 7), 1'b1,
                                            serpent_pkg::lin_inv(pipe_ff[k].data));
            dec_out = t_dec ^ rk_ff[31 - k];
         end
      end

      always_comb begin
         pipe_in[k+1].op   = pipe_ff[k].op;
         pipe_in[k+1].data = pipe_ff[k].op ? dec_out : enc_out;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int s = 0; s <= serpent_pkg::NUM_RNDS; s++) pipe_ff[s] <= pipe_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_adv) begin
         valid_ff <= {valid_ff[serpent_pkg::NUM_RNDS-1:0], req_beat};
      end
   end

   // words 0,1 form the low half, words 2,3 the high half
   assign rsp_valid = valid_ff[serpent_pkg::NUM_RNDS];
   assign rsp_data.result_low  = pipe_ff[serpent_pkg::NUM_RNDS].data[1:0];
   assign rsp_data.result_high = pipe_ff[serpent_pkg::NUM_RNDS].data[3:2];

   // no block enters while round keys are being rebuilt
   a_no_beat_busy: assert property (@(posedge clock) disable iff (reset)
      exp_busy |-> !req_beat)
      else $error("block taken during key schedule");

   // a key write always starts a schedule run
   a_csr_starts: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (state_ff == serpent_pkg::EXP_LOAD))
      else $error("key write did not start schedule");

   // schedule run ends right after the last word
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == serpent_pkg::EXP_RUN && cnt_ff == serpent_pkg::LAST_WORD)
      |=> (state_ff == serpent_pkg::EXP_IDLE))
      else $error("schedule run overran");

   // a held result keeps its valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

`default_nettype wire
